// File: hdl/tccw_pkg.sv
// shared types, constants and the microcode program of the text console writer
// no dependencies; imported by tccw_useq and text_console_char_writer_core
package tccw_pkg;

    // screen geometry and field widths
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 4;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int COL_W     = $clog2(COLUMNS + 1);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int IDX_W     = $clog2(CELLS + 1);
    localparam int OFF_W     = $clog2(2 * CELLS);
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int UPC_W     = 5;

    // character codes with special handling
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // microcode step addresses
    typedef enum logic [UPC_W-1:0] {
        U_RST0    = 5'd0,
        U_RST_LP  = 5'd1,
        U_IDLE    = 5'd2,
        U_DISP    = 5'd3,
        U_PUT0    = 5'd4,
        U_SCR0    = 5'd5,
        U_SCR_RD  = 5'd6,
        U_SCR_WR  = 5'd7,
        U_SCR_Z   = 5'd8,
        U_PUT1    = 5'd9,
        U_PUT2    = 5'd10,
        U_CLR0    = 5'd11,
        U_CLR_LP  = 5'd12,
        U_SET0    = 5'd13,
        U_SET1    = 5'd14,
        U_RD0     = 5'd15,
        U_RD1     = 5'd16,
        U_DONE    = 5'd17
    } t_ustep;

    // datapath actions
    typedef enum logic [3:0] {
        A_NOP,
        A_ADDR_ZERO,
        A_FILL_ZERO,
        A_FILL_BLANK,
        A_TAKE,
        A_DISPATCH,
        A_WRAP,
        A_SCR_READ,
        A_SCR_WRITE,
        A_PUT_PREP,
        A_PUT_WRITE,
        A_CLR_START,
        A_SET_POS,
        A_HW_LOAD,
        A_RD_ISSUE,
        A_RD_TAKE
    } t_act;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ITEM,
        C_DISPATCH,
        C_NO_SCROLL,
        C_MOVE_MORE,
        C_LAST,
        C_CTRL_ONLY,
        C_OUT_FREE
    } t_cond;

    // one control word: action, jump when cond holds, else stay or step on
    typedef struct packed {
        t_act   act;
        t_cond  cond;
        t_ustep target;
        logic   stay;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic item;
        logic no_scroll;
        logic move_more;
        logic last;
        logic ctrl_only;
        logic out_free;
        t_op  op;
    } t_ustat;

    // microcode rom
    function automatic t_uword ucode(input t_ustep s);
        t_uword w;
        w = '{act: A_NOP, cond: C_NEVER, target: U_IDLE, stay: 1'b0};
        case (s)
            U_RST0:   w = '{A_ADDR_ZERO,  C_NEVER,     U_IDLE,   1'b0};
            U_RST_LP: w = '{A_FILL_ZERO,  C_LAST,      U_IDLE,   1'b1};
            U_IDLE:   w = '{A_TAKE,       C_ITEM,      U_DISP,   1'b1};
            U_DISP:   w = '{A_DISPATCH,   C_DISPATCH,  U_IDLE,   1'b0};
            U_PUT0:   w = '{A_WRAP,       C_NO_SCROLL, U_PUT1,   1'b0};
            U_SCR0:   w = '{A_ADDR_ZERO,  C_NEVER,     U_IDLE,   1'b0};
            U_SCR_RD: w = '{A_SCR_READ,   C_NEVER,     U_IDLE,   1'b0};
            U_SCR_WR: w = '{A_SCR_WRITE,  C_MOVE_MORE, U_SCR_RD, 1'b0};
            U_SCR_Z:  w = '{A_FILL_ZERO,  C_LAST,      U_PUT1,   1'b1};
            U_PUT1:   w = '{A_PUT_PREP,   C_CTRL_ONLY, U_DONE,   1'b0};
            U_PUT2:   w = '{A_PUT_WRITE,  C_ALWAYS,    U_DONE,   1'b0};
            U_CLR0:   w = '{A_CLR_START,  C_NEVER,     U_IDLE,   1'b0};
            U_CLR_LP: w = '{A_FILL_BLANK, C_LAST,      U_DONE,   1'b1};
            U_SET0:   w = '{A_SET_POS,    C_NEVER,     U_IDLE,   1'b0};
            U_SET1:   w = '{A_HW_LOAD,    C_ALWAYS,    U_DONE,   1'b0};
            U_RD0:    w = '{A_RD_ISSUE,   C_NEVER,     U_IDLE,   1'b0};
            U_RD1:    w = '{A_RD_TAKE,    C_NEVER,     U_IDLE,   1'b0};
            U_DONE:   w = '{A_NOP,        C_OUT_FREE,  U_IDLE,   1'b1};
            default:  w = '{A_NOP,        C_ALWAYS,    U_IDLE,   1'b0};
        endcase
        return w;
    endfunction

    // entry step of each operation
    function automatic t_ustep disp_target(input t_op op);
        t_ustep s;
        s = U_PUT0;
        case (op)
            OP_PUT:   s = U_PUT0;
            OP_CLEAR: s = U_CLR0;
            OP_SET:   s = U_SET0;
            OP_READ:  s = U_RD0;
            default:  s = U_PUT0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/tccw_useq.sv
// microcode sequencer: step counter, control rom and conditional jumps
// depends on tccw_pkg
module tccw_useq
    import tccw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ustat i_stat,
    output t_uword o_uword
);

    t_ustep r_upc;
    t_ustep n_upc;
    t_uword w;
    logic   cond_true;

    // current control word
    assign w       = ucode(r_upc);
    assign o_uword = w;

    // condition select
    always_comb begin
        case (w.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_ITEM:      cond_true = i_stat.item;
            C_DISPATCH:  cond_true = 1'b1;
            C_NO_SCROLL: cond_true = i_stat.no_scroll;
            C_MOVE_MORE: cond_true = i_stat.move_more;
            C_LAST:      cond_true = i_stat.last;
            C_CTRL_ONLY: cond_true = i_stat.ctrl_only;
            C_OUT_FREE:  cond_true = i_stat.out_free;
            default:     cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (w.cond == C_DISPATCH) begin
            n_upc = disp_target(i_stat.op);
        end else if (cond_true) begin
            n_upc = w.target;
        end else if (w.stay) begin
            n_upc = r_upc;
        end else begin
            n_upc = t_ustep'(r_upc + UPC_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_RST0;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// File: hdl/text_console_char_writer_core.sv
// top level of the text console writer: cell store, cursor datapath, handshakes
// depends on tccw_pkg and tccw_useq
//
// usage
// - input channel i_in_valid / o_in_stall carries one command item: put character,
//   clear screen, set cursor or read one byte of the cell store
// - output channel o_out_valid / i_out_stall returns one result item per command:
//   cursor column and row, hardware cursor register and the byte read
// - config channel i_cfg_valid / o_cfg_ready writes the attribute byte; ready is
//   always high, write it only while the block is idle
// - a microcoded sequencer steps one command at a time through a single-port
//   style cell store (one write, one registered read per cycle)
// - a put that moves past the last row first scrolls the store up by one row: a
//   start step, a read and a write per moved cell, then one write per cleared cell
// - a new item can be accepted from the cycle after the previous result is
//   loaded; the block takes no new item while a command is still in progress
// - after reset the store is cleared to zero one cell a cycle, with o_in_stall
//   high; config writes are taken during that time
// - when the receiver stalls, the result waits in the output register; the
//   block still accepts and works on the next item, and holds before loading
//   its result until the register is free
module text_console_char_writer_core
    import tccw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [6:0]        i_new_col,
    input  logic [4:0]        i_new_row,
    input  logic [11:0]       i_byte_offset,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [IDX_W-1:0]  o_hw_cursor_pos,
    output logic [CHAR_W-1:0] o_read_byte,
    // attribute register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    t_uword uw;
    t_ustat st;

    // latched command fields
    t_op               r_op, n_op;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [6:0]        r_ncol, n_ncol;
    logic [4:0]        r_nrow, n_nrow;
    logic [OFF_W-1:0]  r_off, n_off;

    // cursor and work registers
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_hw, n_hw;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [CHAR_W-1:0] r_rd, n_rd;
    logic [ATTR_W-1:0] r_attr;

    // result register
    logic              r_ovalid;
    logic [COL_W-1:0]  r_o_col;
    logic [ROW_W-1:0]  r_o_row;
    logic [IDX_W-1:0]  r_o_hw;
    logic [CHAR_W-1:0] r_o_rd;

    // cell store
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic              item;
    logic              out_free;
    logic              wrap;
    logic              is_bs;
    logic              off_ok;
    logic [IDX_W-1:0]  cur_idx;
    logic [COL_W:0]    tab_col;

    tccw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (st),
        .o_uword (uw)
    );

    // handshakes
    assign o_in_stall  = (uw.act != A_TAKE);
    assign item        = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // decoded conditions
    assign wrap    = (r_char == CH_NEWLINE) || (r_col >= COL_W'(COLUMNS));
    assign is_bs   = (r_char == CH_BACKSPACE);
    assign off_ok  = (r_off < OFF_W'(2 * CELLS));
    assign cur_idx = IDX_W'(r_row) * IDX_W'(COLUMNS) + IDX_W'(r_col);
    assign tab_col = {1'b0, r_col} + (COL_W + 1)'(TAB_WIDTH)
                   - (COL_W + 1)'(r_col % COL_W'(TAB_WIDTH));

    // status to the sequencer
    always_comb begin
        st.item      = item;
        st.no_scroll = !(wrap && (r_row >= ROW_W'(ROWS - 1)));
        st.move_more = (r_addr != IDX_W'(CELLS - COLUMNS - 1));
        st.last      = (r_addr == IDX_W'(CELLS - 1));
        st.ctrl_only = r_char inside {CH_NEWLINE, CH_RETURN, CH_TAB};
        st.out_free  = out_free;
        st.op        = r_op;
    end

    // datapath next values and store access
    always_comb begin
        n_op      = r_op;
        n_char    = r_char;
        n_ncol    = r_ncol;
        n_nrow    = r_nrow;
        n_off     = r_off;
        n_col     = r_col;
        n_row     = r_row;
        n_hw      = r_hw;
        n_addr    = r_addr;
        n_rd      = r_rd;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_addr + IDX_W'(COLUMNS);
        case (uw.act)
            A_ADDR_ZERO: begin
                n_addr = '0;
            end
            A_FILL_ZERO: begin
                mem_we = 1'b1;
                n_addr = r_addr + IDX_W'(1);
            end
            A_FILL_BLANK: begin
                mem_we    = 1'b1;
                mem_wdata = {r_attr, CH_SPACE};
                n_addr    = r_addr + IDX_W'(1);
            end
            A_TAKE: begin
                if (item) begin
                    n_op   = t_op'(i_operation);
                    n_char = i_char_code;
                    n_ncol = i_new_col;
                    n_nrow = i_new_row;
                    n_off  = i_byte_offset;
                end
            end
            A_DISPATCH: begin
                n_rd = '0;
            end
            A_WRAP: begin
                if (wrap) begin
                    n_col = '0;
                    if (r_row < ROW_W'(ROWS - 1)) begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            A_SCR_READ: begin
                mem_re = 1'b1;
            end
            A_SCR_WRITE: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_addr    = r_addr + IDX_W'(1);
            end
            A_PUT_PREP: begin
                case (r_char)
                    CH_RETURN: begin
                        n_col = '0;
                    end
                    CH_TAB: begin
                        if (tab_col > (COL_W + 1)'(COLUMNS)) begin
                            n_col = COL_W'(COLUMNS);
                        end else begin
                            n_col = tab_col[COL_W-1:0];
                        end
                    end
                    CH_BACKSPACE: begin
                        if (r_col != '0) begin
                            n_col = r_col - COL_W'(1);
                        end
                    end
                    default: begin
                        n_col = r_col;
                    end
                endcase
            end
            A_PUT_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = {r_attr, (is_bs ? CH_SPACE : r_char)};
                if (is_bs) begin
                    n_hw = cur_idx;
                end else begin
                    n_hw  = cur_idx + IDX_W'(1);
                    n_col = r_col + COL_W'(1);
                end
            end
            A_CLR_START: begin
                n_addr = '0;
                n_col  = '0;
                n_row  = '0;
            end
            A_SET_POS: begin
                n_col = (r_ncol > 7'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(r_ncol);
                n_row = (r_nrow > 5'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(r_nrow);
            end
            A_HW_LOAD: begin
                n_hw = cur_idx;
            end
            A_RD_ISSUE: begin
                mem_re    = off_ok;
                mem_raddr = r_off[OFF_W-1:1];
            end
            A_RD_TAKE: begin
                if (!off_ok) begin
                    n_rd = '0;
                end else if (r_off[0]) begin
                    n_rd = r_rdata[CELL_W-1:CHAR_W];
                end else begin
                    n_rd = r_rdata[CHAR_W-1:0];
                end
            end
            default: begin
                n_rd = r_rd;
            end
        endcase
    end

    // cell store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_char <= n_char;
        r_ncol <= n_ncol;
        r_nrow <= n_nrow;
        r_off  <= n_off;
        r_addr <= n_addr;
        r_rd   <= n_rd;
    end

    // cursor state and attribute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_hw   <= '0;
            r_attr <= ATTR_RESET;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_hw  <= n_hw;
            if (i_cfg_valid && o_cfg_ready) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (uw.cond == C_OUT_FREE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.cond == C_OUT_FREE && out_free) begin
            r_o_col <= r_col;
            r_o_row <= r_row;
            r_o_hw  <= r_hw;
            r_o_rd  <= r_rd;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_cursor_col    = r_o_col;
    assign o_cursor_row    = r_o_row;
    assign o_hw_cursor_pos = r_o_hw;
    assign o_read_byte     = r_o_rd;

endmodule
